// File: hw/rtl/dfar_pkg.sv
package dfar_pkg;

  localparam int unsigned PosWidth    = 16;
  // Label and end pointers can pass the 16-bit position by one length byte.
  localparam int unsigned LabelWidth  = 17;
  localparam int unsigned HeaderBytes = 12;
  localparam int unsigned AnswerBytes = 16;
  localparam int unsigned EndOffset   = 5;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QAddrWidth  = $clog2(QueueDepth);
  localparam int unsigned QCountWidth = $clog2(QueueDepth + 1);
  localparam int unsigned AnsIdxWidth = $clog2(AnswerBytes);

  typedef enum logic {
    CMD_BYTE,
    CMD_ANSWER
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  data;
    logic        last;
    logic        abort;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Header bytes 2 through 11: flags 0x8180, QD=1, AN=1, NS=0, AR=0.
  function automatic logic [7:0] header_byte(input logic [3:0] idx);
    logic [7:0] res;
    unique case (idx)
      4'd0:    res = 8'h81;
      4'd1:    res = 8'h80;
      4'd3:    res = 8'h01;
      4'd5:    res = 8'h01;
      default: res = 8'h00;
    endcase
    return res;
  endfunction

  // A answer: name pointer, type, class, TTL 60, length 4, address.
  function automatic logic [7:0] answer_byte(input logic [AnsIdxWidth-1:0] idx,
                                             input logic [31:0] addr);
    logic [7:0] res;
    unique case (idx)
      4'd0:    res = 8'hC0;
      4'd1:    res = 8'h0C;
      4'd3:    res = 8'h01;
      4'd5:    res = 8'h01;
      4'd9:    res = 8'h3C;
      4'd11:   res = 8'h04;
      4'd12:   res = addr[31:24];
      4'd13:   res = addr[23:16];
      4'd14:   res = addr[15:8];
      4'd15:   res = addr[7:0];
      default: res = 8'h00;
    endcase
    return res;
  endfunction

endpackage

// File: hw/rtl/dfar_front.sv
module dfar_front import dfar_pkg::*; #(
  parameter int unsigned MAX_REQUEST_BYTES = 512
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_byte_i,
  input  logic          in_last_i,
  input  queue_status_t q_status_i,
  output logic          push_o,
  output cmd_t          cmd_o
);

  localparam logic [LabelWidth-1:0] MaxBytes = LabelWidth'(MAX_REQUEST_BYTES);

  logic [PosWidth-1:0]   pos_q, pos_d;
  logic                  skip_q, skip_d;
  logic [LabelWidth-1:0] next_label_q, next_label_d;
  logic                  have_end_q, have_end_d;
  logic [LabelWidth-1:0] end_pos_q, end_pos_d;

  logic                  accept;
  logic [LabelWidth-1:0] pos_x;
  logic                  label_hit;
  logic                  he_n;
  logic [LabelWidth-1:0] ep_n;

  assign in_ready_o = ~q_status_i.full;
  assign accept     = in_valid_i & in_ready_o;
  assign pos_x      = LabelWidth'(pos_q);
  assign label_hit  = ~have_end_q && (pos_x == next_label_q);
  assign he_n       = have_end_q | (label_hit && (in_byte_i == 8'd0));
  assign ep_n       = (label_hit && (in_byte_i == 8'd0)) ?
                      pos_x + LabelWidth'(EndOffset) : end_pos_q;

  always_comb begin
    pos_d        = pos_q;
    skip_d       = skip_q;
    next_label_d = next_label_q;
    have_end_d   = have_end_q;
    end_pos_d    = end_pos_q;
    push_o       = 1'b0;
    cmd_o        = '{kind: CMD_BYTE, data: 8'd0, last: 1'b1, abort: 1'b1};

    if (accept) begin
      if (skip_q) begin
        // Tail of a finished or aborted request: swallowed silently.
      end else if (pos_x >= MaxBytes) begin
        push_o = 1'b1;
        skip_d = ~in_last_i;
      end else if (pos_q < PosWidth'(HeaderBytes)) begin
        push_o = 1'b1;
        if (!in_last_i) begin
          cmd_o.last  = 1'b0;
          cmd_o.abort = 1'b0;
          cmd_o.data  = (pos_q < PosWidth'(2)) ? in_byte_i
                                               : header_byte(pos_q[3:0] - 4'd2);
          pos_d       = pos_q + PosWidth'(1);
        end
      end else if (he_n && (pos_x + LabelWidth'(1) == ep_n)) begin
        push_o      = 1'b1;
        cmd_o.kind  = CMD_ANSWER;
        cmd_o.data  = in_byte_i;
        cmd_o.last  = 1'b0;
        cmd_o.abort = 1'b0;
        skip_d      = ~in_last_i;
      end else begin
        push_o = 1'b1;
        if (!in_last_i) begin
          cmd_o.data  = in_byte_i;
          cmd_o.last  = 1'b0;
          cmd_o.abort = 1'b0;
          pos_d       = pos_q + PosWidth'(1);
          have_end_d  = he_n;
          end_pos_d   = ep_n;
          if (label_hit && (in_byte_i != 8'd0)) begin
            next_label_d = pos_x + LabelWidth'(in_byte_i) + LabelWidth'(1);
          end
        end
      end

      // Every datagram end starts the next request from scratch.
      if (in_last_i) begin
        pos_d        = '0;
        skip_d       = 1'b0;
        next_label_d = LabelWidth'(HeaderBytes);
        have_end_d   = 1'b0;
        end_pos_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      skip_q       <= 1'b0;
      next_label_q <= LabelWidth'(HeaderBytes);
      have_end_q   <= 1'b0;
      end_pos_q    <= '0;
    end else begin
      pos_q        <= pos_d;
      skip_q       <= skip_d;
      next_label_q <= next_label_d;
      have_end_q   <= have_end_d;
      end_pos_q    <= end_pos_d;
    end
  end

endmodule

// File: hw/rtl/dfar_queue.sv
module dfar_queue import dfar_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cmd_t          push_cmd_i,
  input  logic          pop_i,
  output cmd_t          head_o,
  output queue_status_t status_o
);

  cmd_t                   mem_q [QueueDepth];
  logic [QAddrWidth-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QAddrWidth-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCountWidth-1:0] count_q, count_d;

  assign status_o.full  = (count_q == QCountWidth'(QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QAddrWidth'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + QAddrWidth'(1) : rd_ptr_q;
    count_d  = count_q + QCountWidth'(push_i) - QCountWidth'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// File: hw/rtl/dfar_back.sv
module dfar_back import dfar_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  queue_status_t q_status_i,
  input  cmd_t          head_i,
  output logic          pop_o,
  input  logic [31:0]   addr_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          out_last_o,
  output logic          out_abort_o
);

  localparam logic [AnsIdxWidth-1:0] LastIdx = AnsIdxWidth'(AnswerBytes - 1);

  logic                   valid_q, valid_d;
  logic                   ans_q, ans_d;
  logic [AnsIdxWidth-1:0] idx_q, idx_d;
  logic [7:0]             byte_q, byte_d;
  logic                   last_q, last_d;
  logic                   abort_q, abort_d;
  logic                   load;

  assign load = ~valid_q | out_ready_i;

  always_comb begin
    valid_d = valid_q;
    ans_d   = ans_q;
    idx_d   = idx_q;
    byte_d  = byte_q;
    last_d  = last_q;
    abort_d = abort_q;
    pop_o   = 1'b0;
    if (load) begin
      if (ans_q) begin
        valid_d = 1'b1;
        byte_d  = answer_byte(idx_q, addr_i);
        last_d  = (idx_q == LastIdx);
        abort_d = 1'b0;
        idx_d   = idx_q + AnsIdxWidth'(1);
        ans_d   = (idx_q != LastIdx);
      end else if (!q_status_i.empty) begin
        pop_o   = 1'b1;
        valid_d = 1'b1;
        byte_d  = head_i.data;
        last_d  = head_i.last;
        abort_d = head_i.abort;
        if (head_i.kind == CMD_ANSWER) begin
          ans_d = 1'b1;
          idx_d = '0;
        end
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ans_q   <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      ans_q   <= ans_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    last_q  <= last_d;
    abort_q <= abort_d;
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;
  assign out_abort_o = abort_q;

endmodule

// File: hw/rtl/dns_fixed_answer_responder.sv
// DNS responder that answers each complete query with one fixed A record.
// The request enters on the slave stream one byte per item, tlast on the
// final byte of the datagram. The response leaves on the master stream one
// byte per item; tlast marks its final item and tuser marks an abort item,
// which tells the receiver to drop everything sent for this request.
// The user must write the answer address through cfg_we_i/cfg_wdata_i only
// while idle; the block does not enforce it. The front part classifies each
// request byte in the cycle it is accepted and, unless it swallows the byte,
// pushes a command into a four-entry queue. The back part drains that queue
// into the output register and expands an answer command into the last
// QCLASS byte plus the 16-byte answer record. Each result passes through
// the queue and then the output register.
// Throughput: one request byte per cycle while the queue has room. The
// final QCLASS byte expands into the whole answer record, so the input
// stalls once the queue fills behind the expansion; bytes after the answer
// or after an abort are swallowed at full rate while the queue has room.
// Reset clears the request state, the queue, the output valid flag and the
// address register. When the receiver holds tready low the output item
// holds, the queue fills and s_axis_tready drops.
module dns_fixed_answer_responder import dfar_pkg::*; #(
  parameter int unsigned MAX_REQUEST_BYTES = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] req_byte
  input  logic        s_axis_tlast,  // req_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] resp_byte
  output logic        m_axis_tlast,  // resp_last
  output logic        m_axis_tuser,  // [0] resp_abort
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  logic [31:0]   answer_address_q;
  logic          front_push;
  cmd_t          front_cmd;
  cmd_t          q_head;
  queue_status_t q_status;
  logic          back_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      answer_address_q <= '0;
    end else if (cfg_we_i) begin
      answer_address_q <= cfg_wdata_i;
    end
  end

  dfar_front #(
    .MAX_REQUEST_BYTES(MAX_REQUEST_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .q_status_i (q_status),
    .push_o     (front_push),
    .cmd_o      (front_cmd)
  );

  dfar_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (front_push),
    .push_cmd_i (front_cmd),
    .pop_i      (back_pop),
    .head_o     (q_head),
    .status_o   (q_status)
  );

  dfar_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .head_i      (q_head),
    .pop_o       (back_pop),
    .addr_i      (answer_address_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_abort_o (m_axis_tuser)
  );

  // An abort item always closes its response and carries a zero byte.
  a_abort_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 8'd0))
    else $error("abort item without tlast or with nonzero data");

  // The front never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_push |-> !q_status.full)
    else $error("command queue overflow");

  // The back never pops an empty queue.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_pop |-> !q_status.empty)
    else $error("command queue underflow");

  // A pop always loads a new item into the output register.
  a_pop_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_pop |=> m_axis_tvalid)
    else $error("popped command did not reach the output");

endmodule

// File: dv/dns_fixed_answer_responder_tb.sv
module dns_fixed_answer_responder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dfar_pkg::*;

  localparam int unsigned MaxRequestBytes = 512;
  // Bytes that yield nothing may still be in flight when the last result
  // arrives, so give them time.
  localparam int unsigned SettleCycles = 8;
  // The run is a few thousand request bytes. The slowest legal schedule has
  // the receiver stalling as long as its stall modes allow and the sender
  // gapping between bursts, so this still leaves several times the margin.
  localparam int unsigned CycleLimit = 400_000;

  // Header bytes 2 to 11 of every response: flags, then QD/AN/NS/AR counts.
  localparam logic [7:0] HeaderTail [10] = '{
    8'h81, 8'h80, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00
  };
  // First twelve bytes of the answer record. The address follows them.
  localparam logic [7:0] AnswerHead [12] = '{
    8'hC0, 8'h0C, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h3C,
    8'h00, 8'h04
  };

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } req_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       abort;
  } resp_item_t;

  // How the receiver behaves during one stretch of the run.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_LONG_RUNS
  } stall_mode_e;

  // Kinds of random request.
  typedef enum logic [2:0] {
    SHAPE_WELL_FORMED,
    SHAPE_TRUNCATED,
    SHAPE_NOISE,
    SHAPE_BAD_JUMP,
    SHAPE_SHORT
  } req_shape_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;
  logic        cfg_we_i      = 1'b0;
  logic [31:0] cfg_wdata_i   = '0;

  // Request bytes waiting for the sender, and response items the block owes.
  req_item_t   request_bytes[$];
  resp_item_t  owed_responses[$];
  // Scratch buffer where one request is assembled before it is queued.
  logic [7:0]  request_buf[$];

  // Our own copy of the responder's state.
  logic [31:0] answer_addr;
  logic [15:0] next_pos;
  bit          swallowing;
  int unsigned label_pos;
  bit          name_done;
  int unsigned qclass_end;

  int unsigned bytes_loaded;
  int unsigned bytes_taken;
  int unsigned requests_loaded;
  int unsigned address_writes;
  int unsigned items_checked;
  int unsigned answers_seen;
  int unsigned aborts_seen;
  int unsigned failures;
  int unsigned cycle_count;

  // Sender burst shaping and receiver stall pattern.
  int unsigned burst_left;
  int unsigned gap_left;
  stall_mode_e stall_mode;
  int unsigned stall_span;
  int unsigned stall_run;

  always #1 clk_i = ~clk_i;

  dns_fixed_answer_responder #(
    .MAX_REQUEST_BYTES(MaxRequestBytes)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // ---------------------------------------------------------------------
  // Response predictor
  // ---------------------------------------------------------------------

  function automatic void start_new_datagram();
    next_pos   = '0;
    swallowing = 1'b0;
    label_pos  = HeaderBytes;
    name_done  = 1'b0;
    qclass_end = 0;
  endfunction

  function automatic void owe(input logic [7:0] data, input logic last,
                              input logic abort);
    resp_item_t r;
    r.data  = data;
    r.last  = last;
    r.abort = abort;
    owed_responses.push_back(r);
  endfunction

  // Works out what one accepted request byte makes the block send.
  function automatic void respond_to_byte(input logic [7:0] data, input logic last);
    int unsigned p;
    p = next_pos;
    // After an answer or an abort the rest of the datagram is dropped.
    if (swallowing) begin
      if (last) start_new_datagram();
      return;
    end
    // Too far into the request without finishing the response.
    if (p >= MaxRequestBytes) begin
      owe(8'h00, 1'b1, 1'b1);
      if (last) start_new_datagram();
      else swallowing = 1'b1;
      return;
    end
    if (p < HeaderBytes) begin
      if (last) begin
        // The datagram ends inside the header.
        owe(8'h00, 1'b1, 1'b1);
        start_new_datagram();
        return;
      end
      // The ID is echoed; everything after it is replaced.
      if (p < 2) owe(data, 1'b0, 1'b0);
      else owe(HeaderTail[p-2], 1'b0, 1'b0);
      next_pos = 16'(p + 1);
      return;
    end
    // Question section: follow the label lengths to the root terminator.
    if (!name_done && p == label_pos) begin
      if (data == 8'h00) begin
        name_done  = 1'b1;
        qclass_end = p + EndOffset;
      end else begin
        label_pos = p + data + 1;
      end
    end
    if (name_done && p + 1 == qclass_end) begin
      // Last QCLASS byte, then the whole answer record.
      owe(data, 1'b0, 1'b0);
      for (int i = 0; i < AnswerBytes; i++) begin
        if (i < 12) owe(AnswerHead[i], 1'b0, 1'b0);
        else owe(answer_addr[8*(15-i) +: 8], i == AnswerBytes - 1, 1'b0);
      end
      if (last) start_new_datagram();
      else swallowing = 1'b1;
      return;
    end
    if (last) begin
      // The question was cut short.
      owe(8'h00, 1'b1, 1'b1);
      start_new_datagram();
      return;
    end
    owe(data, 1'b0, 1'b0);
    next_pos = 16'(p + 1);
  endfunction

  // ---------------------------------------------------------------------
  // Request sender: bursts of random length with random gaps in between.
  // ---------------------------------------------------------------------

  always @(posedge clk_i) begin : driver
    req_item_t item;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        respond_to_byte(s_axis_tdata, s_axis_tlast);
        bytes_taken++;
      end
      // Only move on once the current item has been taken.
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (request_bytes.size() != 0) begin
          item = request_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= item.data;
          s_axis_tlast  <= item.last;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // A zero gap joins two bursts into one long unbroken stretch.
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Response checker and receiver stall pattern.
  // ---------------------------------------------------------------------

  always @(posedge clk_i) begin : monitor
    resp_item_t want;
    logic       ready_next;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (owed_responses.size() == 0) begin
          $error("response item with nothing expected: resp_byte %02h resp_last %0b resp_abort %0b",
                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
          failures++;
        end else begin
          want = owed_responses.pop_front();
          if (m_axis_tdata !== want.data) begin
            $error("resp_byte: expected %02h, got %02h", want.data, m_axis_tdata);
            failures++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("resp_last: expected %0b, got %0b", want.last, m_axis_tlast);
            failures++;
          end
          if (m_axis_tuser !== want.abort) begin
            $error("resp_abort: expected %0b, got %0b", want.abort, m_axis_tuser);
            failures++;
          end
          items_checked++;
          if (want.abort) aborts_seen++;
          else if (want.last) answers_seen++;
        end
      end

      // The receiver picks a new stall mode at random whenever its span runs out.
      if (stall_span == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        stall_span = $urandom_range(20, 120);
      end
      stall_span--;
      case (stall_mode)
        STALL_NONE:  ready_next = 1'b1;
        STALL_LIGHT: ready_next = ($urandom_range(0, 3) != 0);
        STALL_HEAVY: ready_next = ($urandom_range(0, 3) == 0);
        default: begin
          if (stall_run != 0) begin
            stall_run--;
            ready_next = 1'b0;
          end else begin
            ready_next = 1'b1;
            if ($urandom_range(0, 7) == 0) stall_run = $urandom_range(5, 20);
          end
        end
      endcase
      m_axis_tready <= ready_next;
    end
  end

  // Watchdog for a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  // Begins a request with the given ID and ten arbitrary header bytes.
  task automatic start_request(input logic [15:0] id);
    request_buf.delete();
    request_buf.push_back(id[15:8]);
    request_buf.push_back(id[7:0]);
    repeat (10) request_buf.push_back(8'($urandom));
  endtask

  task automatic push_label(input logic [7:0] len);
    request_buf.push_back(len);
    repeat (len) request_buf.push_back(8'($urandom));
  endtask

  // Hands the assembled request to the sender, tlast on its final byte.
  task automatic queue_request();
    req_item_t item;
    for (int i = 0; i < request_buf.size(); i++) begin
      item.data = request_buf[i];
      item.last = (i == request_buf.size() - 1);
      request_bytes.push_back(item);
      bytes_loaded++;
    end
    requests_loaded++;
  endtask

  // A request near the size limit: two long labels, the second of length
  // second_len, a terminator where they lead, and filler up to total bytes.
  task automatic queue_long_request(input int unsigned total,
                                    input logic [7:0] second_len);
    int unsigned term;
    term = 268 + second_len + 1;
    start_request(16'($urandom));
    while (request_buf.size() < total) begin
      if (request_buf.size() == 12) request_buf.push_back(8'hFF);
      else if (request_buf.size() == 268) request_buf.push_back(second_len);
      else if (request_buf.size() == term) request_buf.push_back(8'h00);
      else request_buf.push_back(8'($urandom));
    end
    queue_request();
  endtask

  // Mostly well-formed queries with random names; the rest are broken.
  task automatic queue_random_request();
    int unsigned pick;
    int unsigned n;
    int unsigned cut;
    req_shape_e  shape;
    pick = $urandom_range(0, 9);
    if (pick < 6) shape = SHAPE_WELL_FORMED;
    else if (pick == 6) shape = SHAPE_TRUNCATED;
    else if (pick == 7) shape = SHAPE_NOISE;
    else if (pick == 8) shape = SHAPE_BAD_JUMP;
    else shape = SHAPE_SHORT;
    start_request(16'($urandom));
    case (shape)
      SHAPE_WELL_FORMED, SHAPE_TRUNCATED: begin
        n = $urandom_range(0, 4);
        repeat (n) push_label(($urandom_range(0, 7) == 0) ? 8'd63 : 8'($urandom_range(1, 10)));
        request_buf.push_back(8'h00);
        repeat (4) request_buf.push_back(8'($urandom));
        // Often the datagram ends right on QCLASS, otherwise extra records.
        n = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
        repeat (n) request_buf.push_back(8'($urandom));
        if (shape == SHAPE_TRUNCATED) begin
          cut = $urandom_range(1, request_buf.size() - 1);
          while (request_buf.size() > cut) void'(request_buf.pop_back());
        end
      end
      SHAPE_NOISE: begin
        request_buf.delete();
        repeat ($urandom_range(1, 30)) request_buf.push_back(8'($urandom));
      end
      SHAPE_BAD_JUMP: begin
        request_buf.push_back(8'($urandom_range(64, 255)));
        repeat ($urandom_range(0, 20)) request_buf.push_back(8'($urandom));
      end
      default: begin
        n = $urandom_range(1, 12);
        while (request_buf.size() > n) void'(request_buf.pop_back());
      end
    endcase
    queue_request();
  endtask

  // Blocks until every queued byte is taken and every owed item has come,
  // then lets trailing bytes that yield nothing drain out of the block.
  task automatic wait_for_idle();
    while (bytes_taken != bytes_loaded || owed_responses.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Only called while the block is idle, so our copy changes with it.
  task automatic set_answer_address(input logic [31:0] addr);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= addr;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    answer_addr = addr;
    address_writes++;
  endtask

  initial begin : stimulus
    int unsigned phase_start;
    answer_addr = '0;
    start_new_datagram();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests, answered with the reset address.
    // Root name with the smallest ID; the datagram ends on QCLASS.
    start_request(16'h0000);
    request_buf.push_back(8'h00);
    request_buf.push_back(8'h00);
    request_buf.push_back(8'h01);
    request_buf.push_back(8'h00);
    request_buf.push_back(8'h01);
    queue_request();
    // Three-label name, all-ones ID and type, then an extra record.
    start_request(16'hFFFF);
    push_label(8'd3);
    push_label(8'd7);
    push_label(8'd3);
    request_buf.push_back(8'h00);
    repeat (4) request_buf.push_back(8'hFF);
    repeat (11) request_buf.push_back(8'($urandom));
    queue_request();
    // A datagram of a single byte.
    request_buf.delete();
    request_buf.push_back(8'hA5);
    queue_request();
    // Header only, with no question.
    start_request(16'h1234);
    queue_request();
    // Question cut inside a label.
    start_request(16'h5A5A);
    request_buf.push_back(8'h05);
    request_buf.push_back(8'h61);
    request_buf.push_back(8'h62);
    queue_request();
    // Question cut inside QTYPE.
    start_request(16'h0F0F);
    request_buf.push_back(8'h00);
    request_buf.push_back(8'h00);
    queue_request();
    // A compression pointer read as a label length jumps past the data.
    start_request(16'hC33C);
    request_buf.push_back(8'hC0);
    request_buf.push_back(8'h0C);
    repeat (3) request_buf.push_back(8'($urandom));
    queue_request();
    wait_for_idle();

    set_answer_address(32'hFFFF_FFFF);
    // The answer completes on the last byte below the size limit.
    queue_long_request(512, 8'hEE);
    // QCLASS lands on the limit itself, which is also the final byte.
    queue_long_request(513, 8'hEF);
    // The walk crosses the limit and the rest of the datagram is dropped.
    queue_long_request(530, 8'hFF);
    // An ordinary query after all that, with trailing bytes.
    start_request(16'($urandom));
    push_label(8'd3);
    request_buf.push_back(8'h00);
    request_buf.push_back(8'h00);
    request_buf.push_back(8'h1C);
    request_buf.push_back(8'h00);
    request_buf.push_back(8'h01);
    repeat (3) request_buf.push_back(8'($urandom));
    queue_request();
    wait_for_idle();

    // Random traffic under several addresses, the block idle between them.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        1:       set_answer_address(32'h0000_0000);
        2:       set_answer_address(32'h8000_0001);
        default: set_answer_address($urandom);
      endcase
      phase_start = bytes_loaded;
      while (bytes_loaded - phase_start < 55) queue_random_request();
      wait_for_idle();
    end

    $display("Sent %0d requests (%0d bytes) under %0d address writes.",
             requests_loaded, bytes_loaded, address_writes);
    $display("Checked %0d response items: %0d complete answers, %0d aborts.",
             items_checked, answers_seen, aborts_seen);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
